>>> src/dctq_pkg.sv
// ----------------------------------------------------------------------------
// dctq_pkg
// Shared types, command codes and coefficient tables of the 8x8 DCT quantizer.
// ----------------------------------------------------------------------------
package dctq_pkg;

    localparam int unsigned N          = 8;
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned COEF_W     = 12;
    localparam int unsigned MAT_W      = 13;
    localparam int unsigned RCP_W      = 10;
    localparam int unsigned PROD_W     = COEF_W + MAT_W;
    localparam int unsigned ACC_W      = 28;
    localparam int unsigned OUT_W      = 8;
    localparam int unsigned STORE_D    = N * N;
    localparam int unsigned STORE_AW   = $clog2(STORE_D);

    localparam logic [3:0] OP_IDLE    = 4'd0;
    localparam logic [3:0] OP_LOAD    = 4'd1;
    localparam logic [3:0] OP_ROW_MUL = 4'd2;
    localparam logic [3:0] OP_ROW_SUM = 4'd3;
    localparam logic [3:0] OP_COL_RD  = 4'd4;
    localparam logic [3:0] OP_COL_MUL = 4'd5;
    localparam logic [3:0] OP_COL_SUM = 4'd6;
    localparam logic [3:0] OP_QMUL    = 4'd7;
    localparam logic [3:0] OP_QRND    = 4'd8;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] row;
        logic [2:0] col;
        logic [2:0] freq;
        logic [3:0] cnt;
        logic       luma;
    } cmd_t;

    typedef logic signed [MAT_W-1:0] mat_t;
    typedef logic [RCP_W-1:0]        rcp_t;

    localparam mat_t DCT_MAT [N][N] = '{
        '{13'sd1448,  13'sd1448,  13'sd1448,  13'sd1448,
          13'sd1448,  13'sd1448,  13'sd1448,  13'sd1448},
        '{13'sd2009,  13'sd1703,  13'sd1138,  13'sd400,
          -13'sd400,  -13'sd1138, -13'sd1703, -13'sd2009},
        '{13'sd1892,  13'sd784,   -13'sd784,  -13'sd1892,
          -13'sd1892, -13'sd784,  13'sd784,   13'sd1892},
        '{13'sd1703,  -13'sd400,  -13'sd2009, -13'sd1138,
          13'sd1138,  13'sd2009,  13'sd400,   -13'sd1703},
        '{13'sd1448,  -13'sd1448, -13'sd1448, 13'sd1448,
          13'sd1448,  -13'sd1448, -13'sd1448, 13'sd1448},
        '{13'sd1138,  -13'sd2009, 13'sd400,   13'sd1703,
          -13'sd1703, -13'sd400,  13'sd2009,  -13'sd1138},
        '{13'sd784,   -13'sd1892, 13'sd1892,  -13'sd784,
          -13'sd784,  13'sd1892,  -13'sd1892, 13'sd784},
        '{13'sd400,   -13'sd1138, 13'sd1703,  -13'sd2009,
          13'sd2009,  -13'sd1703, 13'sd1138,  -13'sd400}
    };

    localparam rcp_t LUMA_RCP [N][N] = '{
        '{10'd256, 10'd372, 10'd410, 10'd256, 10'd171, 10'd102, 10'd80, 10'd67},
        '{10'd341, 10'd341, 10'd293, 10'd216, 10'd158, 10'd71,  10'd68, 10'd74},
        '{10'd293, 10'd315, 10'd256, 10'd171, 10'd102, 10'd72,  10'd59, 10'd73},
        '{10'd293, 10'd241, 10'd186, 10'd141, 10'd80,  10'd47,  10'd51, 10'd66},
        '{10'd228, 10'd186, 10'd111, 10'd73,  10'd60,  10'd38,  10'd40, 10'd53},
        '{10'd171, 10'd117, 10'd74,  10'd64,  10'd51,  10'd39,  10'd36, 10'd45},
        '{10'd84,  10'd64,  10'd53,  10'd47,  10'd40,  10'd34,  10'd34, 10'd41},
        '{10'd57,  10'd45,  10'd43,  10'd42,  10'd37,  10'd41,  10'd40, 10'd41}
    };

    localparam rcp_t CHROMA_RCP [N][N] = '{
        '{10'd241, 10'd228, 10'd171, 10'd87, 10'd41, 10'd41, 10'd41, 10'd41},
        '{10'd228, 10'd195, 10'd158, 10'd62, 10'd41, 10'd41, 10'd41, 10'd41},
        '{10'd171, 10'd158, 10'd73,  10'd41, 10'd41, 10'd41, 10'd41, 10'd41},
        '{10'd87,  10'd62,  10'd41,  10'd41, 10'd41, 10'd41, 10'd41, 10'd41},
        '{10'd41,  10'd41,  10'd41,  10'd41, 10'd41, 10'd41, 10'd41, 10'd41},
        '{10'd41,  10'd41,  10'd41,  10'd41, 10'd41, 10'd41, 10'd41, 10'd41},
        '{10'd41,  10'd41,  10'd41,  10'd41, 10'd41, 10'd41, 10'd41, 10'd41},
        '{10'd41,  10'd41,  10'd41,  10'd41, 10'd41, 10'd41, 10'd41, 10'd41}
    };

    // shift right by 12, round half away from zero
    function automatic logic [ACC_W-1:0] round_shift12(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] q;
        mag = v[ACC_W-1] ? (~v + 1'b1) : v;
        q   = (mag + ACC_W'(2048)) >> 12;
        return v[ACC_W-1] ? (~q + 1'b1) : q;
    endfunction

endpackage

>>> src/dctq_ram.sv
// ----------------------------------------------------------------------------
// dctq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dctq_ram #(
    parameter int unsigned WIDTH = 12,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> src/dctq_datapath.sv
// ----------------------------------------------------------------------------
// dctq_datapath
// Eight multiply lanes, sum and round, quantizer multiply, transpose store
// and result row buffer.
// ----------------------------------------------------------------------------
module dctq_datapath import dctq_pkg::*; (
    input  logic        aclk,
    input  cmd_t        cmd,
    input  logic [63:0] s_tdata,
    output logic [63:0] m_tdata
);
    logic signed [COEF_W-1:0] x_reg    [N];
    logic signed [PROD_W-1:0] prod_reg [N];
    logic signed [COEF_W-1:0] blk_reg;
    logic signed [ACC_W-1:0]  qprod_reg;
    logic [OUT_W-1:0]         obuf_reg [N][N];

    logic signed [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]         acc_rnd;
    logic [ACC_W-1:0]         q_rnd;
    logic [COEF_W-1:0]        ram_rdata;
    logic [STORE_AW-1:0]      ram_raddr;
    logic [2:0]               cap_idx;
    rcp_t                     rcp;

    always_comb begin
        acc = '0;
        for (int k = 0; k < N; k++) begin
            acc = acc + ACC_W'(prod_reg[k]);
        end
    end

    assign acc_rnd   = round_shift12(acc);
    assign q_rnd     = round_shift12(qprod_reg);
    assign ram_raddr = {cmd.cnt[2:0], cmd.col};
    assign cap_idx   = cmd.cnt[2:0] - 3'd1;
    assign rcp       = cmd.luma ? LUMA_RCP[cmd.freq][cmd.col]
                                : CHROMA_RCP[cmd.freq][cmd.col];

    dctq_ram #(.WIDTH(COEF_W), .DEPTH(STORE_D)) u_store (
        .aclk  (aclk),
        .we    (cmd.op == OP_ROW_SUM),
        .waddr ({cmd.row, cmd.freq}),
        .wdata (acc_rnd[COEF_W-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                for (int k = 0; k < N; k++) begin
                    x_reg[k] <= COEF_W'($signed({1'b0, s_tdata[k*PIX_W +: PIX_W]}))
                                - COEF_W'(128);
                end
            end
            OP_ROW_MUL, OP_COL_MUL: begin
                for (int k = 0; k < N; k++) begin
                    prod_reg[k] <= PROD_W'(x_reg[k]) * PROD_W'(DCT_MAT[cmd.freq][k]);
                end
            end
            OP_COL_RD: begin
                if (cmd.cnt != 4'd0) begin
                    x_reg[cap_idx] <= ram_rdata;
                end
            end
            OP_COL_SUM: begin
                blk_reg <= acc_rnd[COEF_W-1:0];
            end
            OP_QMUL: begin
                qprod_reg <= ACC_W'(blk_reg) * ACC_W'($signed({1'b0, rcp}));
            end
            OP_QRND: begin
                obuf_reg[cmd.freq][cmd.col] <= q_rnd[OUT_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < N; k++) begin
            m_tdata[k*OUT_W +: OUT_W] = obuf_reg[cmd.row][k];
        end
    end
endmodule

>>> src/dctq_ctrl.sv
// ----------------------------------------------------------------------------
// dctq_ctrl
// Sequencer for row pass, column pass, quantization and result rows.
// ----------------------------------------------------------------------------
module dctq_ctrl import dctq_pkg::*; #(
    parameter int unsigned GROUP_BLOCKS = 6,
    parameter int unsigned LUMA_COUNT   = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output logic m_tlast,
    output logic m_tuser,
    output cmd_t cmd
);
    localparam logic [3:0] ST_IN      = 4'd0;
    localparam logic [3:0] ST_ROW_MUL = 4'd1;
    localparam logic [3:0] ST_ROW_SUM = 4'd2;
    localparam logic [3:0] ST_COL_RD  = 4'd3;
    localparam logic [3:0] ST_COL_MUL = 4'd4;
    localparam logic [3:0] ST_COL_SUM = 4'd5;
    localparam logic [3:0] ST_QMUL    = 4'd6;
    localparam logic [3:0] ST_QRND    = 4'd7;
    localparam logic [3:0] ST_OUT     = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [2:0] row_reg, row_next;
    logic [2:0] col_reg, col_next;
    logic [2:0] freq_reg, freq_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [3:0] block_reg, block_next;
    logic       group_end;

    assign group_end = (5'(block_reg) + 5'd1) >= 5'(GROUP_BLOCKS);

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        freq_next  = freq_reg;
        cnt_next   = cnt_reg;
        block_next = block_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tlast    = 1'b0;
        m_tuser    = 1'b0;
        cmd.op     = OP_IDLE;
        cmd.row    = row_reg;
        cmd.col    = col_reg;
        cmd.freq   = freq_reg;
        cmd.cnt    = cnt_reg;
        cmd.luma   = 5'(block_reg) < 5'(LUMA_COUNT);
        case (state_reg)
            ST_IN: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    freq_next  = 3'd0;
                    state_next = ST_ROW_MUL;
                end
            end
            ST_ROW_MUL: begin
                cmd.op     = OP_ROW_MUL;
                state_next = ST_ROW_SUM;
            end
            ST_ROW_SUM: begin
                cmd.op = OP_ROW_SUM;
                if (freq_reg == 3'd7) begin
                    freq_next = 3'd0;
                    if (row_reg == 3'd7) begin
                        row_next   = 3'd0;
                        col_next   = 3'd0;
                        cnt_next   = 4'd0;
                        state_next = ST_COL_RD;
                    end else begin
                        row_next   = row_reg + 3'd1;
                        state_next = ST_IN;
                    end
                end else begin
                    freq_next  = freq_reg + 3'd1;
                    state_next = ST_ROW_MUL;
                end
            end
            ST_COL_RD: begin
                cmd.op = OP_COL_RD;
                if (cnt_reg == 4'd8) begin
                    freq_next  = 3'd0;
                    state_next = ST_COL_MUL;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_COL_MUL: begin
                cmd.op     = OP_COL_MUL;
                state_next = ST_COL_SUM;
            end
            ST_COL_SUM: begin
                cmd.op     = OP_COL_SUM;
                state_next = ST_QMUL;
            end
            ST_QMUL: begin
                cmd.op     = OP_QMUL;
                state_next = ST_QRND;
            end
            ST_QRND: begin
                cmd.op = OP_QRND;
                if (freq_reg == 3'd7) begin
                    freq_next = 3'd0;
                    if (col_reg == 3'd7) begin
                        row_next   = 3'd0;
                        state_next = ST_OUT;
                    end else begin
                        col_next   = col_reg + 3'd1;
                        cnt_next   = 4'd0;
                        state_next = ST_COL_RD;
                    end
                end else begin
                    freq_next  = freq_reg + 3'd1;
                    state_next = ST_COL_MUL;
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                m_tlast  = row_reg == 3'd7;
                m_tuser  = (row_reg == 3'd7) && group_end;
                if (m_tready) begin
                    if (row_reg == 3'd7) begin
                        row_next   = 3'd0;
                        block_next = group_end ? 4'd0 : block_reg + 4'd1;
                        state_next = ST_IN;
                    end else begin
                        row_next = row_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IN;
            row_reg   <= 3'd0;
            col_reg   <= 3'd0;
            freq_reg  <= 3'd0;
            cnt_reg   <= 4'd0;
            block_reg <= 4'd0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            freq_reg  <= freq_next;
            cnt_reg   <= cnt_next;
            block_reg <= block_next;
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result side active together");

    a_resume: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("no return to input after last result row");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready && !m_tvalid)
        else $error("request accepted without row pass");

    a_block_range: assert property (@(posedge aclk) disable iff (!aresetn)
        5'(block_reg) < 5'(GROUP_BLOCKS))
        else $error("block index out of group");
endmodule

>>> src/dct8x8_quantizer.sv
// ----------------------------------------------------------------------------
// dct8x8_quantizer
// 8x8 forward DCT with luma/chroma quantization on a row stream.
// ----------------------------------------------------------------------------
// Input: one request per row of eight pixels on s_tdata, pixel 0 in the low
// byte. Eight rows make a block. Output: eight requests per block on m_tdata,
// one per vertical frequency, coefficient 0 in the low byte; m_tlast marks
// the eighth row of a block, m_tuser the eighth row of the last block of a
// group. The first LUMA_COUNT blocks of a group use the luma table.
// Each input row is loaded, then multiplied and summed for each of eight
// frequencies through the eight multiply lanes. After the eighth row, the
// column pass reads each column from the store, then multiplies, sums,
// quantizes and rounds it for each vertical frequency; its pace is set by
// the single store read port and the single quantizer multiplier.
// Reset returns to the first row of the first block of a group; the store
// needs no clearing. While the receiver stalls the result row is held and
// no input is taken until all eight rows are delivered.
// ----------------------------------------------------------------------------
module dct8x8_quantizer import dctq_pkg::*; #(
    parameter int unsigned GROUP_BLOCKS = 6,
    parameter int unsigned LUMA_COUNT   = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // pixel_0 .. pixel_7
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // coeff_0 .. coeff_7
    output logic        m_tlast,   // last_of_block
    output logic        m_tuser    // last_of_group
);
    cmd_t cmd;

    dctq_ctrl #(
        .GROUP_BLOCKS (GROUP_BLOCKS),
        .LUMA_COUNT   (LUMA_COUNT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd)
    );

    dctq_datapath u_dp (
        .aclk    (aclk),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );
endmodule

>>> test/dct8x8_quantizer_tb.sv
// ----------------------------------------------------------------------------
// dct8x8_quantizer_tb
// Row stream test of the 8x8 DCT quantizer against a local 2-D DCT predictor.
// ----------------------------------------------------------------------------
// Pixel rows go in on the slave stream. Each finished block's eight coefficient
// rows are worked out here and queued. Results are checked in order against
// that queue: coefficients, block end and group end. A directed table comes
// first: a flat mid-gray block with typed zero results, then extreme and
// checkerboard blocks. Random blocks follow. Both sides idle or stall at
// random in phases. The receiver holds off once for a long stretch, and the
// sender once waits until every result has arrived.
// ----------------------------------------------------------------------------
module dct8x8_quantizer_tb;
    import dctq_pkg::*;

    localparam int unsigned GROUP_BLOCKS = 6;
    localparam int unsigned LUMA_COUNT   = 4;
    localparam int unsigned HOLD_CYCLES  = 1000;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [63:0] coeffs;
        logic        blk_end;
        logic        grp_end;
    } coef_row_t;

    typedef struct {
        logic [63:0] pix;
        bit          flat;
    } pix_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    coef_row_t   coef_rows_q[$];
    int          row_store[8][8];
    int unsigned row_pos;
    int unsigned blk_pos;
    int unsigned mismatches;
    int unsigned cycles;
    int unsigned snd_pct;
    int unsigned rcv_pct;
    int unsigned hold_cnt;
    bit          hold_req;
    pix_row_t    dir_rows[24];

    dct8x8_quantizer #(
        .GROUP_BLOCKS(GROUP_BLOCKS),
        .LUMA_COUNT  (LUMA_COUNT)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint round_sh12(input longint v);
        longint mag;
        mag = v < 0 ? -v : v;
        mag = (mag + 2048) >>> 12;
        return v < 0 ? -mag : mag;
    endfunction

    function automatic int wrap12(input longint v);
        logic [11:0] w;
        w = v[11:0];
        return int'($signed(w));
    endfunction

    function automatic void dct8(input int x[8], output int y[8]);
        longint acc;
        for (int u = 0; u < 8; u++) begin
            acc = 0;
            for (int k = 0; k < 8; k++) acc += longint'(x[k]) * longint'(DCT_MAT[u][k]);
            y[u] = wrap12(round_sh12(acc));
        end
    endfunction

    // add one accepted row; on the eighth, queue the block's coefficient rows
    function automatic void add_pixel_row(input logic [63:0] pix, input bit flat);
        int        x[8];
        int        y[8];
        int        coef2d[8][8];
        bit        luma;
        bit        grp_end;
        coef_row_t r;
        longint    q;
        for (int i = 0; i < 8; i++) x[i] = int'(pix[8*i +: 8]) - 128;
        dct8(x, y);
        for (int i = 0; i < 8; i++) row_store[row_pos][i] = y[i];
        if (row_pos < 7) begin
            row_pos++;
            return;
        end
        for (int u = 0; u < 8; u++) begin
            for (int v = 0; v < 8; v++) x[v] = row_store[v][u];
            dct8(x, y);
            for (int v = 0; v < 8; v++) coef2d[v][u] = y[v];
        end
        luma    = blk_pos < LUMA_COUNT;
        grp_end = blk_pos + 1 >= GROUP_BLOCKS;
        for (int v = 0; v < 8; v++) begin
            for (int u = 0; u < 8; u++) begin
                q = round_sh12(longint'(coef2d[v][u]) *
                    longint'(luma ? LUMA_RCP[v][u] : CHROMA_RCP[v][u]));
                r.coeffs[8*u +: 8] = q[7:0];
            end
            if (flat) r.coeffs = 64'h0;
            r.blk_end = v == 7;
            r.grp_end = v == 7 && grp_end;
            coef_rows_q.push_back(r);
        end
        row_pos = 0;
        blk_pos = grp_end ? 0 : blk_pos + 1;
    endfunction

    task automatic send_row(input logic [63:0] pix, input bit flat);
        int unsigned gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < snd_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        add_pixel_row(pix, flat);
    endtask

    function automatic logic [7:0] rand_pixel(input int unsigned mode, input int unsigned base);
        case (mode)
            0: return 8'($urandom_range(255));
            1: return $urandom_range(1) ? 8'd255 : 8'd0;
            2: return 8'((base + $urandom_range(15)) & 8'hff);
            default: return 8'(base);
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            m_tready <= $urandom_range(99) >= rcv_pct;
        end
    end

    always @(posedge aclk) begin
        coef_row_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (coef_rows_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: data %h last %b user %b",
                             m_tdata, m_tlast, m_tuser);
            end else begin
                want = coef_rows_q.pop_front();
                for (int u = 0; u < 8; u++) begin
                    if (m_tdata[8*u +: 8] !== want.coeffs[8*u +: 8]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("coeff_%0d: expected %0d got %0d", u,
                                     $signed(want.coeffs[8*u +: 8]),
                                     $signed(m_tdata[8*u +: 8]));
                    end
                end
                if (m_tlast !== want.blk_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("last_of_block: expected %b got %b", want.blk_end, m_tlast);
                end
                if (m_tuser !== want.grp_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("last_of_group: expected %b got %b", want.grp_end, m_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL dct8x8_quantizer");
            $finish;
        end
    end

    initial begin
        int unsigned mode;
        int unsigned base;
        logic [63:0] pix;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 64'h0;
        m_tready    = 1'b0;
        hold_req    = 1'b0;
        snd_pct     = 0;
        rcv_pct     = 0;
        cycles      = 0;
        mismatches  = 0;
        row_pos     = 0;
        blk_pos     = 0;
        // flat mid-gray: every coefficient is zero
        for (int i = 0; i < 8; i++) dir_rows[i] = '{{8{8'd128}}, 1'b1};
        // full-scale extremes and alternating columns
        dir_rows[8]  = '{{8{8'd0}}, 1'b0};
        dir_rows[9]  = '{{8{8'd255}}, 1'b0};
        dir_rows[10] = '{{4{8'd255, 8'd0}}, 1'b0};
        dir_rows[11] = '{{4{8'd0, 8'd255}}, 1'b0};
        dir_rows[12] = '{{{4{8'd255}}, {4{8'd0}}}, 1'b0};
        dir_rows[13] = '{{{4{8'd0}}, {4{8'd255}}}, 1'b0};
        dir_rows[14] = '{{8{8'd255}}, 1'b0};
        dir_rows[15] = '{{8{8'd0}}, 1'b0};
        // checkerboard, strongest high-frequency content
        for (int i = 16; i < 24; i++)
            dir_rows[i] = '{(i % 2) ? {4{8'd0, 8'd255}} : {4{8'd255, 8'd0}}, 1'b0};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_row(dir_rows[i].pix, dir_rows[i].flat);
        s_tvalid <= 1'b0;
        while (coef_rows_q.size() != 0) @(posedge aclk);
        @(posedge aclk);

        for (int b = 0; b < 13; b++) begin
            case ((b / 2) % 4)
                0: begin snd_pct = 0;  rcv_pct <= 0;  end
                1: begin snd_pct = 75; rcv_pct <= 0;  end
                2: begin snd_pct = 0;  rcv_pct <= 75; end
                default: begin snd_pct = 19; rcv_pct <= 19; end
            endcase
            if (b == 2) hold_req <= 1'b1;
            mode = $urandom_range(3);
            base = $urandom_range(255);
            for (int r = 0; r < 8; r++) begin
                for (int i = 0; i < 8; i++) pix[8*i +: 8] = rand_pixel(mode, base);
                send_row(pix, 1'b0);
            end
        end
        s_tvalid <= 1'b0;

        while (coef_rows_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (mismatches == 0 && coef_rows_q.size() == 0) begin
            $display("PASS dct8x8_quantizer");
        end else begin
            $display("FAIL dct8x8_quantizer");
        end
        $finish;
    end

endmodule

>>> sim.f
src/dctq_pkg.sv
src/dctq_ram.sv
src/dctq_datapath.sv
src/dctq_ctrl.sv
src/dct8x8_quantizer.sv
test/dct8x8_quantizer_tb.sv
